FILE: hw/rtl/pkc_pkg.sv
// ----------------------------------------------------------------------------
// pkc_pkg
// Shared types, register codes and the wrapped elapsed-time compare for the
// power key controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pkc_pkg;

  localparam int unsigned TICK_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ON_HOLD_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SETTLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_OFF_WAIT  = 3'd3;

  // Register values after reset
  localparam logic [CFG_W-1:0] ON_HOLD_MIN_RST    = 16'd5000;
  localparam logic [CFG_W-1:0] RELEASE_SETTLE_RST = 16'd5000;
  localparam logic [CFG_W-1:0] LONG_PRESS_MIN_RST = 16'd50000;
  localparam logic [CFG_W-1:0] AUTO_OFF_WAIT_RST  = 16'd50000;

  typedef struct packed {
    logic [CFG_W-1:0] on_hold_min;
    logic [CFG_W-1:0] release_settle;
    logic [CFG_W-1:0] long_press_min;
    logic [CFG_W-1:0] auto_off_wait;
  } pkc_cfg_t;

  typedef struct packed {
    logic power_on_pulse;
    logic force_shutdown;
    logic notice_pending;
    logic query_reason;
  } pkc_result_t;

  // Elapsed time from b to e exceeds t; a backward step counts through wrap
  function automatic logic elapsed_over(input logic [TICK_W-1:0] b,
                                        input logic [TICK_W-1:0] e,
                                        input logic [CFG_W-1:0]  t,
                                        input logic [TICK_W-1:0] wrap);
    logic [TICK_W-1:0] span;
    if (e >= b) begin
      span = e - b;
    end else begin
      span = (wrap - b) + e;
    end
    return span > {{(TICK_W-CFG_W){1'b0}}, t};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/power_key_controller.sv
// ----------------------------------------------------------------------------
// power_key_controller
// Power key press tracking: power-on pulse, long-press shutdown notice and
// forced shutdown after the auto wait.
//
//   channel  handshake              payload
//   in_      in_valid / in_stall    key_pressed, rail_on, now_ticks, query_notice
//   out_     out_valid / out_stall  power_on_pulse, force_shutdown,
//                                   notice_pending, query_reason
//   cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data (16 bit)
//
// One word in per cycle while in_stall is low; its result goes to the output
// register, or to the skid entry if that is held. The state update is one pass
// of compare/subtract logic. A two-entry output buffer absorbs one result while
// out_stall is high; in_stall rises only when both entries are full. Reset clears
// all key state and loads the register defaults; configuration is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module power_key_controller
  import pkc_pkg::*;
#(
  parameter logic [31:0] TIME_WRAP = 32'hFFFF_FFFF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_key_pressed,
  input  wire logic                 in_rail_on,
  input  wire logic [TICK_W-1:0]    in_now_ticks,
  input  wire logic                 in_query_notice,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_power_on_pulse,
  output logic                      out_force_shutdown,
  output logic                      out_notice_pending,
  output logic                      out_query_reason,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  pkc_cfg_t    cfg_r;
  pkc_result_t step_res;
  pkc_result_t main_r, skid_r;
  logic        main_valid_r, skid_valid_r;
  logic        accept, pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign pop       = main_valid_r && !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_hold_min    <= ON_HOLD_MIN_RST;
      cfg_r.release_settle <= RELEASE_SETTLE_RST;
      cfg_r.long_press_min <= LONG_PRESS_MIN_RST;
      cfg_r.auto_off_wait  <= AUTO_OFF_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ON_HOLD_MIN:    cfg_r.on_hold_min    <= cfg_data;
        REG_RELEASE_SETTLE: cfg_r.release_settle <= cfg_data;
        REG_LONG_PRESS_MIN: cfg_r.long_press_min <= cfg_data;
        REG_AUTO_OFF_WAIT:  cfg_r.auto_off_wait  <= cfg_data;
        default: ;
      endcase
    end
  end

  pkc_core #(
    .TIME_WRAP(TIME_WRAP)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (accept),
    .key_pressed (in_key_pressed),
    .rail_on     (in_rail_on),
    .now_ticks   (in_now_ticks),
    .query_notice(in_query_notice),
    .cfg         (cfg_r),
    .result      (step_res)
  );

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= accept;
        main_r       <= step_res;
      end
    end else if (accept) begin
      if (!main_valid_r) begin
        main_valid_r <= 1'b1;
        main_r       <= step_res;
      end else begin
        skid_valid_r <= 1'b1;
        skid_r       <= step_res;
      end
    end
  end

  assign out_valid          = main_valid_r;
  assign out_power_on_pulse = main_r.power_on_pulse;
  assign out_force_shutdown = main_r.force_shutdown;
  assign out_notice_pending = main_r.notice_pending;
  assign out_query_reason   = main_r.query_reason;

endmodule

`default_nettype wire

FILE: hw/rtl/pkc_core.sv
// ----------------------------------------------------------------------------
// pkc_core
// Press tracking state for the power-on and power-off paths, auto shutdown
// timer and host notice. Updates state and forms one result per step.
// ----------------------------------------------------------------------------
`default_nettype none

module pkc_core
  import pkc_pkg::*;
#(
  parameter logic [31:0] TIME_WRAP = 32'hFFFF_FFFF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic              key_pressed,
  input  wire logic              rail_on,
  input  wire logic [TICK_W-1:0] now_ticks,
  input  wire logic              query_notice,
  input  wire pkc_cfg_t          cfg,
  output pkc_result_t            result
);

  logic              on_pressed_r, on_released_r, off_pressed_r, off_released_r;
  logic              auto_armed_r, notice_flag_r;
  logic [TICK_W-1:0] on_press_time_r, on_release_time_r;
  logic [TICK_W-1:0] off_press_time_r, off_release_time_r, auto_start_time_r;

  logic              on_pressed_nxt, on_released_nxt, off_pressed_nxt, off_released_nxt;
  logic              auto_armed_nxt, notice_flag_nxt;
  logic [TICK_W-1:0] on_press_time_nxt, on_release_time_nxt;
  logic [TICK_W-1:0] off_press_time_nxt, off_release_time_nxt, auto_start_time_nxt;

  // Walk one poll through whichever path owns the key
  always_comb begin
    on_pressed_nxt       = on_pressed_r;
    on_released_nxt      = on_released_r;
    on_press_time_nxt    = on_press_time_r;
    on_release_time_nxt  = on_release_time_r;
    off_pressed_nxt      = off_pressed_r;
    off_released_nxt     = off_released_r;
    off_press_time_nxt   = off_press_time_r;
    off_release_time_nxt = off_release_time_r;
    auto_armed_nxt       = auto_armed_r;
    auto_start_time_nxt  = auto_start_time_r;
    notice_flag_nxt      = notice_flag_r;
    result               = '0;

    priority if ((!rail_on || on_pressed_r) && !off_pressed_r) begin
      // power-on path
      if (!on_pressed_nxt && key_pressed) begin
        on_pressed_nxt    = 1'b1;
        on_press_time_nxt = now_ticks;
      end
      if (on_pressed_nxt && !on_released_nxt && !key_pressed) begin
        on_released_nxt     = 1'b1;
        on_release_time_nxt = now_ticks;
      end
      if (on_released_nxt) begin
        if (elapsed_over(on_press_time_nxt, on_release_time_nxt, cfg.on_hold_min,
                         TIME_WRAP)) begin
          result.power_on_pulse = 1'b1;
          on_pressed_nxt        = 1'b0;
          on_released_nxt       = 1'b0;
          on_press_time_nxt     = '0;
          on_release_time_nxt   = '0;
          auto_armed_nxt        = 1'b0;
          auto_start_time_nxt   = '0;
        end
        if (key_pressed) begin
          on_released_nxt = 1'b0;
        end
      end
    end else if ((rail_on || off_pressed_r) && !on_pressed_r) begin
      // power-off path
      if (!off_pressed_nxt && key_pressed) begin
        off_pressed_nxt    = 1'b1;
        off_press_time_nxt = now_ticks;
      end
      if (off_pressed_nxt && !off_released_nxt && !key_pressed) begin
        off_released_nxt     = 1'b1;
        off_release_time_nxt = now_ticks;
      end
      if (off_released_nxt) begin
        // drop a press whose release has settled
        if (elapsed_over(off_release_time_nxt, now_ticks, cfg.release_settle,
                         TIME_WRAP)) begin
          off_pressed_nxt      = 1'b0;
          off_released_nxt     = 1'b0;
          off_press_time_nxt   = '0;
          off_release_time_nxt = '0;
        end
        // long press: raise notice and arm the auto timer
        if (elapsed_over(off_press_time_nxt, off_release_time_nxt, cfg.long_press_min,
                         TIME_WRAP)) begin
          notice_flag_nxt      = 1'b1;
          off_pressed_nxt      = 1'b0;
          off_released_nxt     = 1'b0;
          off_press_time_nxt   = '0;
          off_release_time_nxt = '0;
          auto_armed_nxt       = 1'b1;
          auto_start_time_nxt  = now_ticks;
        end
        if (key_pressed) begin
          off_released_nxt = 1'b0;
        end
      end
      // auto timer expiry
      if (auto_armed_nxt && elapsed_over(auto_start_time_nxt, now_ticks, cfg.auto_off_wait,
                                         TIME_WRAP)) begin
        auto_armed_nxt        = 1'b0;
        auto_start_time_nxt   = '0;
        notice_flag_nxt       = 1'b0;
        result.force_shutdown = rail_on;
      end
    end

    // serve the host query after the key logic
    if (query_notice && notice_flag_nxt) begin
      notice_flag_nxt     = 1'b0;
      result.query_reason = 1'b1;
    end
    result.notice_pending = notice_flag_nxt;
  end

  // Hold state between polls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_pressed_r       <= 1'b0;
      on_released_r      <= 1'b0;
      on_press_time_r    <= '0;
      on_release_time_r  <= '0;
      off_pressed_r      <= 1'b0;
      off_released_r     <= 1'b0;
      off_press_time_r   <= '0;
      off_release_time_r <= '0;
      auto_armed_r       <= 1'b0;
      auto_start_time_r  <= '0;
      notice_flag_r      <= 1'b0;
    end else if (step_en) begin
      on_pressed_r       <= on_pressed_nxt;
      on_released_r      <= on_released_nxt;
      on_press_time_r    <= on_press_time_nxt;
      on_release_time_r  <= on_release_time_nxt;
      off_pressed_r      <= off_pressed_nxt;
      off_released_r     <= off_released_nxt;
      off_press_time_r   <= off_press_time_nxt;
      off_release_time_r <= off_release_time_nxt;
      auto_armed_r       <= auto_armed_nxt;
      auto_start_time_r  <= auto_start_time_nxt;
      notice_flag_r      <= notice_flag_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: dv/power_key_controller_tb.sv
// ----------------------------------------------------------------------------
// power_key_controller_tb
// Self-checking bench for the power key controller. Drives polls of key
// level, rail state and timestamp, predicts each result word with an
// in-bench copy of the press tracking, and checks every word on the result
// channel. Directed corner cases come first, then randomized press sequences
// under several register settings, mostly with random gaps and stalls.
// ----------------------------------------------------------------------------
module power_key_controller_tb;
  import pkc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TICK_W-1:0] WRAP = 32'hFFFF_FFFF;
  // Index outside the register map; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_key_pressed = 1'b0;
  logic                 in_rail_on = 1'b0;
  logic [TICK_W-1:0]    in_now_ticks = '0;
  logic                 in_query_notice = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_power_on_pulse;
  logic                 out_force_shutdown;
  logic                 out_notice_pending;
  logic                 out_query_reason;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  power_key_controller #(
    .TIME_WRAP(WRAP)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key_pressed    (in_key_pressed),
    .in_rail_on        (in_rail_on),
    .in_now_ticks      (in_now_ticks),
    .in_query_notice   (in_query_notice),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_power_on_pulse(out_power_on_pulse),
    .out_force_shutdown(out_force_shutdown),
    .out_notice_pending(out_notice_pending),
    .out_query_reason  (out_query_reason),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted register file and key tracking state
  logic [CFG_W-1:0]  hold_min, settle_ticks, long_min, auto_wait;
  logic              on_down, on_up, off_down, off_up, timer_armed, notice;
  logic [TICK_W-1:0] on_t_press, on_t_rel, off_t_press, off_t_rel, arm_t;

  pkc_result_t       expected_results[$];
  int unsigned       mismatch_count = 0;
  int unsigned       polls_sent = 0;
  bit                idle_bursts = 1'b0;
  int unsigned       stall_left = 0;
  logic [TICK_W-1:0] tick_now = '0;

  // Span from one timestamp to another, counted through the wrap value
  function automatic logic span_exceeds(input logic [TICK_W-1:0] from_t,
                                        input logic [TICK_W-1:0] to_t,
                                        input logic [CFG_W-1:0]  limit);
    logic [TICK_W-1:0] span;
    span = (to_t >= from_t) ? to_t - from_t : (WRAP - from_t) + to_t;
    return span > TICK_W'(limit);
  endfunction

  task automatic reset_tracking();
    hold_min     = ON_HOLD_MIN_RST;
    settle_ticks = RELEASE_SETTLE_RST;
    long_min     = LONG_PRESS_MIN_RST;
    auto_wait    = AUTO_OFF_WAIT_RST;
    {on_down, on_up, off_down, off_up, timer_armed, notice} = '0;
    {on_t_press, on_t_rel, off_t_press, off_t_rel, arm_t} = '0;
  endtask

  task automatic drop_off_press();
    off_down    = 1'b0;
    off_up      = 1'b0;
    off_t_press = '0;
    off_t_rel   = '0;
  endtask

  // Advance the tracking state by one poll and form its result word
  task automatic predict_poll(input logic key, input logic rail,
                              input logic [TICK_W-1:0] now, input logic query,
                              output pkc_result_t r);
    r = '0;
    if ((!rail || on_down) && !off_down) begin
      if (!on_down && key) begin
        on_down    = 1'b1;
        on_t_press = now;
      end
      if (on_down && !on_up && !key) begin
        on_up    = 1'b1;
        on_t_rel = now;
      end
      if (on_up) begin
        if (span_exceeds(on_t_press, on_t_rel, hold_min)) begin
          r.power_on_pulse = 1'b1;
          {on_down, on_up, timer_armed} = '0;
          {on_t_press, on_t_rel, arm_t} = '0;
        end
        // glitch: pressed again, keep the original press time
        if (key) on_up = 1'b0;
      end
    end else if ((rail || off_down) && !on_down) begin
      if (!off_down && key) begin
        off_down    = 1'b1;
        off_t_press = now;
      end
      if (off_down && !off_up && !key) begin
        off_up    = 1'b1;
        off_t_rel = now;
      end
      if (off_up) begin
        if (span_exceeds(off_t_rel, now, settle_ticks)) drop_off_press();
        if (span_exceeds(off_t_press, off_t_rel, long_min)) begin
          notice = 1'b1;
          drop_off_press();
          timer_armed = 1'b1;
          arm_t       = now;
        end
        if (key) off_up = 1'b0;
      end
      if (timer_armed && span_exceeds(arm_t, now, auto_wait)) begin
        timer_armed = 1'b0;
        arm_t       = '0;
        notice      = 1'b0;
        if (rail) r.force_shutdown = 1'b1;
      end
    end
    // the host read comes after this poll's key handling
    if (query && notice) begin
      notice         = 1'b0;
      r.query_reason = 1'b1;
    end
    r.notice_pending = notice;
  endtask

  // Send one poll word; predict on acceptance
  task automatic send_poll(input logic key, input logic rail,
                           input logic [TICK_W-1:0] now, input logic query);
    pkc_result_t r;
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_key_pressed  <= key;
    in_rail_on      <= rail;
    in_now_ticks    <= now;
    in_query_notice <= query;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_poll(key, rail, now, query, r);
    expected_results.push_back(r);
    polls_sent++;
    @(negedge clk);
  endtask

  // Hold the input side quiet until every result word has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ON_HOLD_MIN:    hold_min     = val;
      REG_RELEASE_SETTLE: settle_ticks = val;
      REG_LONG_PRESS_MIN: long_min     = val;
      REG_AUTO_OFF_WAIT:  auto_wait    = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] settle,
                              input logic [CFG_W-1:0] long_p, input logic [CFG_W-1:0] wait_t);
    write_reg(REG_ON_HOLD_MIN, hold);
    write_reg(REG_RELEASE_SETTLE, settle);
    write_reg(REG_LONG_PRESS_MIN, long_p);
    write_reg(REG_AUTO_OFF_WAIT, wait_t);
    write_reg(REG_SPARE, CFG_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic host_reads();
    return $urandom_range(0, 7) == 0;
  endfunction

  // Pick a duration around a threshold, with exact-boundary hits
  function automatic logic [TICK_W-1:0] near_threshold(input logic [CFG_W-1:0] thr);
    logic [TICK_W-1:0] t;
    t = TICK_W'(thr);
    case ($urandom_range(0, 5))
      0:       return (t == 0) ? t : t - 1;
      1:       return t;
      2:       return t + 1;
      3:       return $urandom_range(0, t);
      4:       return t + $urandom_range(1, 2000);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // One press/release with held polls, glitches and settle/expiry polls after
  task automatic key_sequence();
    logic              rail;
    logic [TICK_W-1:0] left, step;
    rail = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) tick_now = WRAP - $urandom_range(0, 70000);
    repeat ($urandom_range(0, 2)) begin
      tick_now += $urandom_range(1, 200);
      send_poll(1'b0, rail, tick_now, host_reads());
    end
    tick_now += $urandom_range(1, 50);
    send_poll(1'b1, rail, tick_now, host_reads());
    left = near_threshold(rail ? long_min : hold_min);
    repeat ($urandom_range(0, 3)) begin
      step = $urandom_range(0, left);
      tick_now += step;
      left -= step;
      send_poll($urandom_range(0, 4) != 0, rail, tick_now, host_reads());
    end
    tick_now += left;
    send_poll(1'b0, rail, tick_now, host_reads());
    repeat ($urandom_range(1, 3)) begin
      tick_now += near_threshold($urandom_range(0, 1) ? settle_ticks : auto_wait);
      if ($urandom_range(0, 5) == 0) rail = ~rail;
      send_poll($urandom_range(0, 5) == 0, rail, tick_now, host_reads());
    end
  endtask

  // Program the registers, then run sequences mixed with unstructured polls
  task automatic run_phase(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] settle,
                           input logic [CFG_W-1:0] long_p, input logic [CFG_W-1:0] wait_t,
                           input int unsigned n_polls, input bit gaps);
    int unsigned target;
    wait_idle();
    program_regs(hold, settle, long_p, wait_t);
    idle_bursts = gaps;
    target = polls_sent + n_polls;
    while (polls_sent < target) begin
      if ($urandom_range(0, 6) == 0) begin
        send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 1) ? TICK_W'($urandom()) : tick_now + $urandom_range(0, 9),
                  1'($urandom_range(0, 1)));
      end else begin
        key_sequence();
      end
    end
  endtask

  function automatic logic [CFG_W-1:0] random_reg();
    case ($urandom_range(0, 3))
      0:       return CFG_W'($urandom_range(0, 20));
      1:       return CFG_W'($urandom_range(0, 2000));
      2:       return CFG_W'($urandom());
      default: return '1;
    endcase
  endfunction

  // Boundaries, wrap, glitch, same-poll query and both timer expiry cases
  task automatic test_directed_cases();
    idle_bursts = 1'b0;
    // press exactly at the on threshold, glitch, then release past it
    send_poll(1'b1, 1'b0, 32'd1000, 1'b0);
    send_poll(1'b0, 1'b0, 32'd6000, 1'b0);
    send_poll(1'b1, 1'b0, 32'd6500, 1'b0);
    send_poll(1'b0, 1'b0, 32'd7000, 1'b0);
    // press across the timestamp wrap
    send_poll(1'b1, 1'b0, 32'hFFFF_FF00, 1'b0);
    send_poll(1'b0, 1'b0, 32'h0000_1400, 1'b0);
    // long press with the host reading in the same poll
    send_poll(1'b1, 1'b1, 32'd100, 1'b0);
    send_poll(1'b0, 1'b1, 32'd50101, 1'b1);
    // auto timer runs out with the rail on
    send_poll(1'b0, 1'b1, 32'd100102, 1'b0);
    // press exactly at the long threshold, then abandon after settle
    send_poll(1'b1, 1'b1, 32'd200000, 1'b0);
    send_poll(1'b0, 1'b1, 32'd250000, 1'b0);
    send_poll(1'b0, 1'b1, 32'd255001, 1'b0);
    // notice left pending, timer expires with the rail off
    send_poll(1'b1, 1'b1, 32'd300000, 1'b0);
    send_poll(1'b0, 1'b1, 32'd360000, 1'b0);
    send_poll(1'b1, 1'b1, 32'd361000, 1'b0);
    send_poll(1'b1, 1'b0, 32'd420000, 1'b0);
    send_poll(1'b0, 1'b0, 32'd420001, 1'b0);
    send_poll(1'b0, 1'b0, 32'd420002, 1'b1);
    // power-on pulse disarms a running timer
    send_poll(1'b1, 1'b0, 32'd430000, 1'b0);
    send_poll(1'b0, 1'b0, 32'd436000, 1'b0);
    // query with nothing pending
    send_poll(1'b0, 1'b1, 32'd500000, 1'b1);
    // timestamp extremes
    send_poll(1'b1, 1'b0, 32'h0000_0000, 1'b0);
    send_poll(1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_threshold_extremes();
    run_phase('0, '0, '0, '0, 200, 1'b1);
    run_phase('1, '1, '1, '1, 200, 1'b1);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      run_phase(random_reg(), random_reg(), random_reg(), random_reg(), 200,
                $urandom_range(0, 2) != 0);
    end
  endtask

  task automatic test_steady_stream();
    run_phase(ON_HOLD_MIN_RST, RELEASE_SETTLE_RST, LONG_PRESS_MIN_RST, AUTO_OFF_WAIT_RST,
              250, 1'b0);
  endtask

  // Random output stalls in bursts while enabled
  always @(negedge clk) begin
    if (!rst_n || !idle_bursts) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result word against the oldest prediction
  always @(posedge clk) begin : result_check
    pkc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %b", $time,
                 {out_power_on_pulse, out_force_shutdown, out_notice_pending,
                  out_query_reason});
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("power_on_pulse", want.power_on_pulse, out_power_on_pulse);
        check_field("force_shutdown", want.force_shutdown, out_force_shutdown);
        check_field("notice_pending", want.notice_pending, out_notice_pending);
        check_field("query_reason", want.query_reason, out_query_reason);
      end
    end
  end

  initial begin
    reset_tracking();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_threshold_extremes();
    test_random_settings();
    test_steady_stream();
    wait_idle();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
